// File: hw/rtl/pr3d_pkg.sv
// Shared types, constants and sine table for the 3D Euler point rotation unit.
package pr3d_pkg;

    localparam int CoefWidth  = 17;
    localparam int AngleWidth = 9;
    localparam int IndexWidth = 2;

    localparam logic [IndexWidth-1:0] REG_ANGLE_X = 2'd0;
    localparam logic [IndexWidth-1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [IndexWidth-1:0] REG_ANGLE_Z = 2'd2;

    typedef logic signed [CoefWidth-1:0] t_coef_val;

    typedef struct packed {
        t_coef_val cx;
        t_coef_val sx;
        t_coef_val nsx;
        t_coef_val cy;
        t_coef_val sy;
        t_coef_val nsy;
        t_coef_val cz;
        t_coef_val sz;
        t_coef_val nsz;
    } t_coef;

    // quarter-wave sine, Q1.15, 32768 = 1.0
    localparam logic [15:0] SINE_Q15 [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32525, 16'd32589,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    function automatic logic [AngleWidth-1:0] mod360(input logic [AngleWidth-1:0] a);
        logic [AngleWidth-1:0] r;
        begin
            r = (a >= 9'd360) ? (a - 9'd360) : a;
            return r;
        end
    endfunction

    // a is already below 360
    function automatic t_coef_val sin_deg(input logic [AngleWidth-1:0] a);
        logic [AngleWidth-1:0] k;
        logic                  neg;
        t_coef_val             mag;
        begin
            if (a <= 9'd90) begin
                k   = a;
                neg = 1'b0;
            end else if (a <= 9'd180) begin
                k   = 9'd180 - a;
                neg = 1'b0;
            end else if (a <= 9'd270) begin
                k   = a - 9'd180;
                neg = 1'b1;
            end else begin
                k   = 9'd360 - a;
                neg = 1'b1;
            end
            mag = $signed({1'b0, SINE_Q15[k[6:0]]});
            return neg ? -mag : mag;
        end
    endfunction

    function automatic t_coef_val cos_deg(input logic [AngleWidth-1:0] a);
        logic [AngleWidth-1:0] s;
        begin
            s = mod360(a + 9'd90);
            return sin_deg(s);
        end
    endfunction

endpackage

// File: hw/rtl/pr3d_coef.sv
// Angle registers and registered sine/cosine coefficients.
module pr3d_coef import pr3d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [IndexWidth-1:0] i_cfg_index,
    input  logic [AngleWidth-1:0] i_cfg_data,
    output t_coef                 o_coef
);

    logic [AngleWidth-1:0] r_ang_x, r_ang_y, r_ang_z;
    logic [AngleWidth-1:0] ax, ay, az;
    t_coef                 r_coef, n_coef;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_x <= '0;
            r_ang_y <= '0;
            r_ang_z <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ANGLE_X: r_ang_x <= i_cfg_data;
                REG_ANGLE_Y: r_ang_y <= i_cfg_data;
                REG_ANGLE_Z: r_ang_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ax = mod360(r_ang_x);
        ay = mod360(r_ang_y);
        az = mod360(r_ang_z);
        n_coef.cx  = cos_deg(ax);
        n_coef.sx  = sin_deg(ax);
        n_coef.nsx = -sin_deg(ax);
        n_coef.cy  = cos_deg(ay);
        n_coef.sy  = sin_deg(ay);
        n_coef.nsy = -sin_deg(ay);
        n_coef.cz  = cos_deg(az);
        n_coef.sz  = sin_deg(az);
        n_coef.nsz = -sin_deg(az);
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

// File: hw/rtl/pr3d_rot.sv
// Two-stage plane rotation: products, then rounded sums, with a side field.
module pr3d_rot import pr3d_pkg::*; #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int WP = 32,
    parameter int WO = 34
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [WA-1:0] i_a,
    input  logic signed [WB-1:0] i_b,
    input  logic        [WP-1:0] i_pass,
    input  t_coef_val            i_ca1,
    input  t_coef_val            i_cb1,
    input  t_coef_val            i_ca2,
    input  t_coef_val            i_cb2,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [WO-1:0] o_r1,
    output logic signed [WO-1:0] o_r2,
    output logic        [WP-1:0] o_pass
);

    localparam int WM = (WA > WB) ? WA : WB;
    localparam int WS = WM + CoefWidth + 1;
    localparam logic signed [WS-1:0] HALF = WS'(16384);

    logic                             r_vld1, r_vld2;
    logic                             en1, en2;
    logic signed [WA+CoefWidth-1:0]   r_pa1, r_pa2;
    logic signed [WB+CoefWidth-1:0]   r_pb1, r_pb2;
    logic        [WP-1:0]             r_pass1, r_pass2;
    logic signed [WS-1:0]             n_s1, n_s2;
    logic signed [WO-1:0]             r_r1, r_r2;

    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_valid;
            if (en2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pa1   <= i_a * i_ca1;
            r_pb1   <= i_b * i_cb1;
            r_pa2   <= i_a * i_ca2;
            r_pb2   <= i_b * i_cb2;
            r_pass1 <= i_pass;
        end
    end

    // floor((sum + 2^14) / 2^15); the result is known to fit WO bits
    always_comb begin
        n_s1 = WS'(r_pa1) + WS'(r_pb1) + HALF;
        n_s2 = WS'(r_pa2) + WS'(r_pb2) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_r1    <= n_s1[15 +: WO];
            r_r2    <= n_s2[15 +: WO];
            r_pass2 <= r_pass1;
        end
    end

    assign o_valid = r_vld2;
    assign o_r1    = r_r1;
    assign o_r2    = r_r2;
    assign o_pass  = r_pass2;

endmodule

// File: hw/rtl/point_rotate_3d_euler_unit.sv
// Top level of the 3D Euler point rotation unit (x, then y, then z).
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: x_in, y_in, z_in
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: x_out, y_out, z_out
//  cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data (angle, degrees)
//
// One point per cycle sustained while m_axis_tready stays high; registered path: input register, three
// two-stage multiply/round rotations, saturating output register.
// Synchronous active-low reset clears valid bits and the angles to 0.
// Every stage has its own enable, so bubbles close up behind a stalled output.
// Coefficients are registered from the angles in the cycle after a write.
module point_rotate_3d_euler_unit import pr3d_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_in, y_in, z_in, zero pad
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // x_out, y_out, z_out, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [IndexWidth-1:0]               i_cfg_index,
    input  logic [AngleWidth-1:0]               i_cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = ((3*W+7)/8)*8;

    t_coef coef;

    logic                r_in_vld, en_in;
    logic signed [W-1:0] r_x, r_y, r_z;

    logic                r1_vld, r1_rdy;
    logic signed [W+1:0] b1, c1;
    logic        [W-1:0] x1;

    logic                r2_vld, r2_rdy;
    logic signed [W+2:0] d2, zo2;
    logic        [W+1:0] b2;

    logic                r3_vld, r3_rdy;
    logic signed [W+3:0] yo3, xo3;
    logic        [W+2:0] zo3;

    logic                r_out_vld, en_out;
    logic        [W-1:0] r_xo, r_yo, r_zo;

    function automatic logic [W-1:0] sat(input logic signed [W+3:0] v);
        logic [4:0] top;
        begin
            top = v[W+3:W-1];
            if ((&top) || !(|top)) return v[W-1:0];
            else if (v[W+3])       return {1'b1, {(W-1){1'b0}}};
            else                   return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    pr3d_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    assign en_in         = !r_in_vld || r1_rdy;
    assign s_axis_tready = en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en_in) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_x <= s_axis_tdata[0 +: W];
            r_y <= s_axis_tdata[W +: W];
            r_z <= s_axis_tdata[2*W +: W];
        end
    end

    // about x: B = y*cx + z*sx, C = z*cx - y*sx
    pr3d_rot #(.WA(W), .WB(W), .WP(W), .WO(W+2)) u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .o_ready (r1_rdy),
        .i_a     (r_y),
        .i_b     (r_z),
        .i_pass  (r_x),
        .i_ca1   (coef.cx),
        .i_cb1   (coef.sx),
        .i_ca2   (coef.nsx),
        .i_cb2   (coef.cx),
        .o_valid (r1_vld),
        .i_ready (r2_rdy),
        .o_r1    (b1),
        .o_r2    (c1),
        .o_pass  (x1)
    );

    // about y: D = x*cy - C*sy, z_out = x*sy + C*cy
    pr3d_rot #(.WA(W), .WB(W+2), .WP(W+2), .WO(W+3)) u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_vld),
        .o_ready (r2_rdy),
        .i_a     ($signed(x1)),
        .i_b     (c1),
        .i_pass  (b1),
        .i_ca1   (coef.cy),
        .i_cb1   (coef.nsy),
        .i_ca2   (coef.sy),
        .i_cb2   (coef.cy),
        .o_valid (r2_vld),
        .i_ready (r3_rdy),
        .o_r1    (d2),
        .o_r2    (zo2),
        .o_pass  (b2)
    );

    // about z: y_out = B*cz - D*sz, x_out = B*sz + D*cz
    pr3d_rot #(.WA(W+2), .WB(W+3), .WP(W+3), .WO(W+4)) u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .o_ready (r3_rdy),
        .i_a     ($signed(b2)),
        .i_b     (d2),
        .i_pass  (zo2),
        .i_ca1   (coef.cz),
        .i_cb1   (coef.nsz),
        .i_ca2   (coef.sz),
        .i_cb2   (coef.cz),
        .o_valid (r3_vld),
        .i_ready (en_out),
        .o_r1    (yo3),
        .o_r2    (xo3),
        .o_pass  (zo3)
    );

    assign en_out = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en_out) begin
            r_out_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_xo <= sat(xo3);
            r_yo <= sat(yo3);
            r_zo <= sat((W+4)'($signed(zo3)));
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = DW'({r_zo, r_yo, r_xo});

endmodule
